>>> rtl/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// Types and constants for the API frame receiver core.
// ----------------------------------------------------------------------------
`default_nettype none

package afr_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h7E;
    localparam logic [7:0] GOOD_SUM  = 8'hFF;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_LINE     = 2'd2;
    localparam logic [1:0] ST_ZERO_LEN = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_error;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
        logic [1:0]  status;
        logic        last;
    } out_item_t;

endpackage

`default_nettype wire

>>> rtl/api_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// api_frame_receiver_core
// Hunts for sync, parses length and type, passes payload bytes straight out
// and closes each frame with an end item carrying type, length and status.
// ----------------------------------------------------------------------------
//  channel | direction | ports                       | item
//  s_      | in        | s_valid, s_ready, s_item    | received byte + line error
//  m_      | out       | m_valid, m_ready, m_item    | payload byte or frame end
//
//  One item per cycle sustained while m_ does not stall; an accepted item passes
//  the input register, then the parser and the result register.
//  Synchronous active-low reset returns the parser to sync hunt, empties both
//  registers. A stall on m_ holds the input register, and s_ready falls once
//  it is full. Items that give no result (header bytes) still wait their turn.
// ----------------------------------------------------------------------------
`default_nettype none

module api_frame_receiver_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire afr_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output afr_pkg::out_item_t     m_item
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_TYPE    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [15:0]        length_reg, length_next;
    logic [15:0]        count_reg, count_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         type_reg, type_next;

    logic               in_valid_reg;
    afr_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    afr_pkg::out_item_t out_item_reg;

    logic               advance;
    logic               has_result;
    afr_pkg::out_item_t result;
    logic [15:0]        len_full;
    logic [7:0]         total;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    assign len_full = {length_reg[15:8], in_item_reg.rx_byte};
    assign total    = sum_reg + in_item_reg.rx_byte;

    always_comb begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        type_next   = type_reg;
        has_result  = 1'b0;
        result      = '0;
        case (phase_reg)
            PH_LEN_HI: begin
                length_next = {in_item_reg.rx_byte, 8'h00};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                length_next = len_full;
                if (len_full == 16'd0) begin
                    phase_next          = PH_HUNT;
                    has_result          = 1'b1;
                    result.kind         = afr_pkg::KIND_END;
                    result.status       = afr_pkg::ST_ZERO_LEN;
                    result.last         = 1'b1;
                end else begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_next  = in_item_reg.rx_byte;
                sum_next   = in_item_reg.rx_byte;
                count_next = 16'd0;
                phase_next = (length_reg == 16'd1) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                sum_next   = total;
                count_next = count_reg + 16'd1;
                if (count_next >= length_reg - 16'd1) begin
                    phase_next = PH_CHECK;
                end
                has_result          = 1'b1;
                result.kind         = afr_pkg::KIND_PAYLOAD;
                result.data         = in_item_reg.rx_byte;
                result.frame_type   = type_reg;
                result.frame_length = length_reg;
                result.status       = afr_pkg::ST_OK;
            end
            PH_CHECK: begin
                phase_next          = PH_HUNT;
                has_result          = 1'b1;
                result.kind         = afr_pkg::KIND_END;
                result.frame_type   = type_reg;
                result.frame_length = length_reg;
                result.last         = 1'b1;
                if (total != afr_pkg::GOOD_SUM) begin
                    result.status = afr_pkg::ST_CHECKSUM;
                end else if (in_item_reg.line_error) begin
                    result.status = afr_pkg::ST_LINE;
                end else begin
                    result.status = afr_pkg::ST_OK;
                end
            end
            default: begin
                phase_next = PH_HUNT;
                if (in_item_reg.rx_byte == afr_pkg::SYNC_BYTE && !in_item_reg.line_error) begin
                    phase_next = PH_LEN_HI;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            length_reg    <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            type_reg      <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                phase_reg     <= phase_next;
                length_reg    <= length_next;
                count_reg     <= count_next;
                sum_reg       <= sum_next;
                type_reg      <= type_next;
                out_valid_reg <= has_result;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance && has_result) begin
            out_item_reg <= result;
        end
    end

endmodule

`default_nettype wire

>>> rtl/afr_checker.sv
// ----------------------------------------------------------------------------
// afr_checker
// Port-level checks on the result channel of the frame receiver core.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire afr_pkg::out_item_t m_item
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_item))
        else $error("result changed while stalled");

    a_payload_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind == afr_pkg::KIND_PAYLOAD |->
            m_item.status == afr_pkg::ST_OK && !m_item.last)
        else $error("payload item with status or last set");

    a_end_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind == afr_pkg::KIND_END |->
            m_item.last && m_item.data == 8'h00)
        else $error("frame end item malformed");

    a_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == afr_pkg::ST_ZERO_LEN |->
            m_item.frame_length == 16'd0 && m_item.frame_type == 8'h00)
        else $error("zero length end with non-zero fields");

endmodule

bind api_frame_receiver_core afr_checker u_afr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

>>> test/tb_api_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// tb_api_frame_receiver_core
// Self-checking bench for the API frame receiver core. A queue of received
// bytes feeds a valid/ready driver, and a parse model predicts each payload
// or frame-end item. A monitor checks every result against the oldest
// prediction. Directed frames come first, then random frames, noise and
// broken frames under three idling mixes, with one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_api_frame_receiver_core;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_TYPE    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } parse_phase_t;

    localparam int STALL_CYCLES = 300;
    localparam int PHASE_BYTES  = 370;

    localparam int MODE_GOOD     = 0;
    localparam int MODE_BAD_SUM  = 1;
    localparam int MODE_LINE_ERR = 2;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    afr_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    afr_pkg::out_item_t m_item;

    afr_pkg::in_item_t  rx_bytes_q[$];
    afr_pkg::out_item_t frame_results_q[$];

    parse_phase_t rx_phase      = PH_HUNT;
    logic [15:0]  frame_len     = '0;
    logic [15:0]  payload_taken = '0;
    logic [7:0]   frame_sum     = '0;
    logic [7:0]   frame_type_q  = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic stall_req   = 1'b0;
    logic stall_done  = 1'b0;
    int hold_left     = 0;

    int stim_count     = 0;
    int bytes_taken    = 0;
    int payload_seen   = 0;
    int ends_seen      = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int fail_count     = 0;
    int mismatch_count = 0;
    int report_count   = 0;

    api_frame_receiver_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic parse_rx_byte(input afr_pkg::in_item_t it);
        afr_pkg::out_item_t r;
        logic [7:0]         total;
        logic               gives;
        r = '0;
        gives = 1'b0;
        case (rx_phase)
            PH_LEN_HI: begin
                frame_len = {it.rx_byte, 8'h00};
                rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                frame_len = frame_len | {8'h00, it.rx_byte};
                if (frame_len == 16'd0) begin
                    rx_phase = PH_HUNT;
                    r.kind = afr_pkg::KIND_END;
                    r.status = afr_pkg::ST_ZERO_LEN;
                    r.last = 1'b1;
                    gives = 1'b1;
                end else begin
                    rx_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                frame_type_q = it.rx_byte;
                frame_sum = it.rx_byte;
                payload_taken = '0;
                rx_phase = (frame_len == 16'd1) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                frame_sum = frame_sum + it.rx_byte;
                payload_taken = payload_taken + 16'd1;
                if (payload_taken >= frame_len - 16'd1)
                    rx_phase = PH_CHECK;
                r.kind = afr_pkg::KIND_PAYLOAD;
                r.data = it.rx_byte;
                r.frame_type = frame_type_q;
                r.frame_length = frame_len;
                r.status = afr_pkg::ST_OK;
                gives = 1'b1;
            end
            PH_CHECK: begin
                total = frame_sum + it.rx_byte;
                if (total != afr_pkg::GOOD_SUM)
                    r.status = afr_pkg::ST_CHECKSUM;
                else if (it.line_error)
                    r.status = afr_pkg::ST_LINE;
                else
                    r.status = afr_pkg::ST_OK;
                rx_phase = PH_HUNT;
                r.kind = afr_pkg::KIND_END;
                r.frame_type = frame_type_q;
                r.frame_length = frame_len;
                r.last = 1'b1;
                gives = 1'b1;
            end
            default: begin
                if (it.rx_byte == afr_pkg::SYNC_BYTE && !it.line_error)
                    rx_phase = PH_LEN_HI;
                else
                    rx_phase = PH_HUNT;
            end
        endcase
        if (gives)
            frame_results_q.push_back(r);
    endtask

    task automatic put_byte(input logic [7:0] b, input logic err);
        afr_pkg::in_item_t it;
        it.rx_byte = b;
        it.line_error = err;
        rx_bytes_q.push_back(it);
        stim_count++;
    endtask

    function automatic logic rand_err(input int pct);
        return ($urandom_range(99) < pct);
    endfunction

    // modes: good checksum, bad checksum, good checksum with line error
    task automatic put_frame(input int len, input logic [7:0] ftype, input int mode,
                             input int err_pct);
        logic [15:0] l;
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [7:0]  chk;
        l = len[15:0];
        put_byte(afr_pkg::SYNC_BYTE, 1'b0);
        put_byte(l[15:8], rand_err(err_pct));
        put_byte(l[7:0], rand_err(err_pct));
        if (l == 16'd0)
            return;
        put_byte(ftype, rand_err(err_pct));
        sum = ftype;
        for (int i = 1; i < len; i++) begin
            b = 8'($urandom);
            sum = sum + b;
            put_byte(b, rand_err(err_pct));
        end
        chk = afr_pkg::GOOD_SUM - sum;
        case (mode)
            MODE_GOOD:    put_byte(chk, 1'b0);
            MODE_BAD_SUM: put_byte(chk ^ 8'($urandom_range(1, 255)), rand_err(50));
            default:      put_byte(chk, 1'b1);
        endcase
    endtask

    task automatic put_random_traffic(input int target);
        int start;
        int sel;
        int len;
        int mode;
        int n;
        start = stim_count;
        while (stim_count - start < target) begin
            sel = $urandom_range(99);
            if (sel < 75) begin
                len = (sel < 10) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                mode = $urandom_range(99);
                mode = (mode < 70) ? MODE_GOOD : (mode < 85) ? MODE_BAD_SUM : MODE_LINE_ERR;
                put_frame(len, 8'($urandom), mode, 10);
            end else if (sel < 83) begin
                put_frame(0, 8'h00, MODE_GOOD, 10);
            end else if (sel < 91) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(99) < 30)
                        put_byte(afr_pkg::SYNC_BYTE, 1'b1);
                    else
                        put_byte(8'($urandom), rand_err(50));
                end
            end else begin
                // frame cut short; following bytes land in its later fields
                put_byte(afr_pkg::SYNC_BYTE, 1'b0);
                n = $urandom_range(1, 4);
                repeat (n) put_byte(8'($urandom), rand_err(20));
            end
        end
    endtask

    task automatic drain_rx;
        while (rx_bytes_q.size() != 0 || s_valid)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin : drive_rx
        afr_pkg::in_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_rx_byte(s_item);
                bytes_taken++;
            end
            if (s_valid && !s_ready) begin
                // hold the offered item
            end else if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = rx_bytes_q.pop_front();
                s_valid <= 1'b1;
                s_item <= nxt;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : long_stall
        if (stall_req && !stall_done) begin
            stall_done <= 1'b1;
            hold_left <= STALL_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : watch_results
        afr_pkg::out_item_t want;
        afr_pkg::out_item_t got;
        logic               bad;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = m_item;
                if (frame_results_q.size() == 0) begin
                    fail_count++;
                    if (report_count < 10)
                        $display("%0t unexpected: k %0d d %02h t %02h n %04h s %0d l %0d",
                                 $realtime, got.kind, got.data, got.frame_type,
                                 got.frame_length, got.status, got.last);
                    report_count++;
                end else begin
                    want = frame_results_q.pop_front();
                    bad = (want.kind !== got.kind) || (want.data !== got.data) ||
                          (want.frame_type !== got.frame_type) ||
                          (want.frame_length !== got.frame_length) ||
                          (want.status !== got.status) || (want.last !== got.last);
                    if (bad) begin
                        mismatch_count++;
                        if (report_count < 10) begin
                            $display("%0t exp: k %0d d %02h t %02h n %04h s %0d l %0d",
                                     $realtime, want.kind, want.data, want.frame_type,
                                     want.frame_length, want.status, want.last);
                            $display("%0t got: k %0d d %02h t %02h n %04h s %0d l %0d",
                                     $realtime, got.kind, got.data, got.frame_type,
                                     got.frame_length, got.status, got.last);
                        end
                        report_count++;
                    end
                end
                if (got.kind == afr_pkg::KIND_END) begin
                    ends_seen++;
                    status_seen[got.status]++;
                end else begin
                    payload_seen++;
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("api_frame_receiver_core regression: fail");
        $finish;
    end

    initial begin : run
        int guard;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct <= 23;
        recv_idle_pct <= 61;
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(afr_pkg::SYNC_BYTE, 1'b1);
        // length one, no payload
        put_byte(afr_pkg::SYNC_BYTE, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h01, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        // zero length
        put_byte(afr_pkg::SYNC_BYTE, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        // line errors on header and payload ignored, good sum with line error
        put_byte(afr_pkg::SYNC_BYTE, 1'b0);
        put_byte(8'h00, 1'b1);
        put_byte(8'h03, 1'b1);
        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b1);
        put_byte(8'h80, 1'b0);
        put_byte(8'h80, 1'b1);
        // bad sum wins over line error
        put_byte(afr_pkg::SYNC_BYTE, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h02, 1'b0);
        put_byte(8'h10, 1'b0);
        put_byte(8'h20, 1'b0);
        put_byte(8'h00, 1'b1);
        put_random_traffic(PHASE_BYTES);
        drain_rx();

        send_idle_pct <= 61;
        recv_idle_pct <= 23;
        put_random_traffic(PHASE_BYTES);
        drain_rx();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        stall_req <= 1'b1;
        put_random_traffic(PHASE_BYTES);
        put_frame(16'h0100 + $urandom_range(0, 63), 8'($urandom), MODE_GOOD, 5);
        put_random_traffic(20);
        drain_rx();

        guard = 0;
        while (frame_results_q.size() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (frame_results_q.size() != 0) begin
            fail_count++;
            $display("%0d predicted items never arrived", frame_results_q.size());
        end

        $display("sent %0d bytes; checked %0d payload items and %0d frame ends",
                 bytes_taken, payload_seen, ends_seen);
        $display("frame ends: ok %0d, bad sum %0d, line err %0d, zero len %0d; %0d mismatches",
                 status_seen[afr_pkg::ST_OK], status_seen[afr_pkg::ST_CHECKSUM],
                 status_seen[afr_pkg::ST_LINE], status_seen[afr_pkg::ST_ZERO_LEN],
                 mismatch_count);
        if (fail_count == 0 && mismatch_count == 0) begin
            $display("api_frame_receiver_core regression: pass");
        end else begin
            $display("api_frame_receiver_core regression: fail");
        end
        $finish;
    end

endmodule
